// File: rtl/dvrt_pkg.sv
// Shared types and constants of the distance-vector route table.
// No dependencies; imported by every module of the block.
`default_nettype none

package dvrt_pkg;

   // Default table depth, handed down from the top level.
   localparam int DEPTH_DEFAULT = 32;

   // Field widths.
   localparam int ID_W      = 8;
   localparam int COST_W    = 16;
   localparam int FUNC_W    = 2;
   localparam int COUNT_W   = 6;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 16;

   localparam logic [COST_W-1:0] COST_MAX = '1;

   // Operation codes carried in req_tuser.
   localparam logic [FUNC_W-1:0] OP_CLEAR    = 2'd0;
   localparam logic [FUNC_W-1:0] OP_ADD_NBR  = 2'd1;
   localparam logic [FUNC_W-1:0] OP_ADD_SELF = 2'd2;
   localparam logic [FUNC_W-1:0] OP_APPLY    = 2'd3;

   // One stored route.
   typedef struct packed {
      logic [ID_W-1:0]   dest;
      logic [ID_W-1:0]   hop;
      logic [COST_W-1:0] cost;
   } route_entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;      // latch the accepted request
      logic exec;         // run clear / add neighbour / add self
      logic scan;         // read the next entry and check the previous one
      logic hit_update;   // matching entry found: apply update rule
      logic miss_append;  // no match: append the advertised route
      logic emit;         // move the finished result into the output register
   } dvrt_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic hit;          // entry under check matches the destination
      logic exhausted;    // all valid entries checked, none matched
      logic slot_free;    // output register empty or being drained
   } dvrt_status_type;

endpackage : dvrt_pkg

`default_nettype wire

// File: rtl/dvrt_ctrl.sv
// Sequencer of the route table: accepts requests and steps the datapath.
// Depends on dvrt_pkg for the command and status structs.
`default_nettype none

module dvrt_ctrl
   import dvrt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [FUNC_W-1:0] req_tuser,
   input  wire dvrt_status_type   status,
   output dvrt_cmd_type           cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = (req_tuser == OP_APPLY) ? ST_SCAN : ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_EMIT;
         end
         ST_SCAN: begin
            if (status.hit) begin
               cmd.hit_update = 1'b1;
               state_in       = ST_EMIT;
            end else if (status.exhausted) begin
               cmd.miss_append = 1'b1;
               state_in        = ST_EMIT;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : dvrt_ctrl

`default_nettype wire

// File: rtl/dvrt_dp.sv
// Datapath of the route table: route memory, fill count, packet flag,
// search registers and output register. Depends on dvrt_pkg.
`default_nettype none

module dvrt_dp
   import dvrt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dvrt_cmd_type          cmd,
   output dvrt_status_type            status,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [FUNC_W-1:0]     req_tuser,
   input  wire logic                  req_tlast,
   input  wire logic                  csr_valid,
   input  wire logic [ID_W-1:0]       csr_data,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   // Request fields.
   logic [ID_W-1:0]   req_dest;
   logic [ID_W-1:0]   req_advhop;
   logic [COST_W-1:0] req_acost;
   logic [ID_W-1:0]   req_sender;
   logic [COST_W-1:0] req_lcost;
   logic [COST_W:0]   cost_sum;

   assign req_dest   = req_tdata[7:0];
   assign req_advhop = req_tdata[15:8];
   assign req_acost  = req_tdata[31:16];
   assign req_sender = req_tdata[39:32];
   assign req_lcost  = req_tdata[55:40];
   assign cost_sum   = {1'b0, req_acost} + {1'b0, req_lcost};

   // Latched request; cost holds the saturated sum for apply, the raw cost otherwise.
   logic [FUNC_W-1:0] func_ff;
   logic [ID_W-1:0]   dest_ff;
   logic [ID_W-1:0]   advhop_ff;
   logic [ID_W-1:0]   sender_ff;
   logic [COST_W-1:0] cost_ff;
   logic              last_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= req_tuser;
         dest_ff   <= req_dest;
         advhop_ff <= req_advhop;
         sender_ff <= req_sender;
         last_ff   <= req_tlast;
         if (req_tuser == OP_APPLY) begin
            cost_ff <= cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
         end else begin
            cost_ff <= req_acost;
         end
      end
   end

   // Control state.
   logic [ID_W-1:0]  my_id_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             pkt_flag_ff;
   logic             pkt_flag_in;
   logic [CNT_W-1:0] scan_ff;
   logic             chk_valid_ff;
   logic             rsp_valid_ff;

   // Memory and search registers.
   route_entry_type  route_mem [TABLE_DEPTH];
   route_entry_type  rd_data_ff;
   logic [IDX_W-1:0] rd_addr_ff;
   logic             rd_en;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   route_entry_type  wr_entry;

   // Pending result.
   logic res_load;
   logic res_changed;
   logic res_pkt;
   logic res_full;
   logic res_changed_ff;
   logic res_pkt_ff;
   logic res_full_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic             tbl_full;
   logic             better;
   logic             follow;
   logic [CNT_W+COUNT_W-1:0] count_ext;

   assign tbl_full = (count_ff >= DEPTH_CNT);
   assign rd_en    = cmd.scan && (scan_ff < count_ff);

   // Update rule on the entry under check: split-horizon improvement first,
   // then forced follow of a route through the sender.
   assign better = (cost_ff < rd_data_ff.cost) && (advhop_ff != my_id_ff);
   assign follow = (rd_data_ff.hop == sender_ff) && (rd_data_ff.cost != cost_ff);

   assign status.hit       = chk_valid_ff && (rd_data_ff.dest == dest_ff);
   assign status.exhausted = !chk_valid_ff && (scan_ff >= count_ff);
   assign status.slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = count_ff[IDX_W-1:0];
      wr_entry    = rd_data_ff;
      count_in    = count_ff;
      pkt_flag_in = pkt_flag_ff;
      res_load    = 1'b0;
      res_changed = 1'b0;
      res_pkt     = 1'b0;
      res_full    = 1'b0;

      if (cmd.exec) begin
         res_load = 1'b1;
         unique case (func_ff)
            OP_CLEAR: begin
               count_in    = '0;
               pkt_flag_in = 1'b0;
            end
            OP_ADD_NBR: begin
               if (tbl_full) begin
                  res_full = 1'b1;
               end else begin
                  wr_en       = 1'b1;
                  wr_entry    = '{dest: dest_ff, hop: dest_ff, cost: cost_ff};
                  count_in    = count_ff + CNT_W'(1);
                  res_changed = 1'b1;
               end
            end
            OP_ADD_SELF: begin
               if (tbl_full) begin
                  res_full = 1'b1;
               end else begin
                  wr_en       = 1'b1;
                  wr_entry    = '{dest: my_id_ff, hop: my_id_ff, cost: '0};
                  count_in    = count_ff + CNT_W'(1);
                  res_changed = 1'b1;
               end
            end
            OP_APPLY: begin
               res_load = 1'b0;
            end
            default: res_load = 1'b0;
         endcase
      end

      if (cmd.hit_update) begin
         res_load    = 1'b1;
         res_changed = better || follow;
         wr_en       = res_changed;
         wr_addr     = rd_addr_ff;
         wr_entry    = '{dest: rd_data_ff.dest,
                         hop:  better ? sender_ff : rd_data_ff.hop,
                         cost: cost_ff};
      end

      if (cmd.miss_append) begin
         res_load = 1'b1;
         if (tbl_full) begin
            res_full = 1'b1;
         end else begin
            wr_en       = 1'b1;
            wr_entry    = '{dest: dest_ff, hop: sender_ff, cost: cost_ff};
            count_in    = count_ff + CNT_W'(1);
            res_changed = 1'b1;
         end
      end

      // Packet flag: OR in this item, clear after the last route of a packet.
      if (cmd.hit_update || cmd.miss_append) begin
         res_pkt     = pkt_flag_ff || res_changed;
         pkt_flag_in = last_ff ? 1'b0 : res_pkt;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= route_mem[scan_ff[IDX_W-1:0]];
         rd_addr_ff <= scan_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         my_id_ff     <= '0;
         count_ff     <= '0;
         pkt_flag_ff  <= 1'b0;
         scan_ff      <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            my_id_ff <= csr_data;
         end
         count_ff    <= count_in;
         pkt_flag_ff <= pkt_flag_in;
         if (cmd.capture) begin
            scan_ff      <= '0;
            chk_valid_ff <= 1'b0;
         end else if (cmd.scan) begin
            chk_valid_ff <= rd_en;
            if (rd_en) begin
               scan_ff <= scan_ff + CNT_W'(1);
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign count_ext = {{COUNT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (res_load) begin
         res_changed_ff <= res_changed;
         res_pkt_ff     <= res_pkt;
         res_full_ff    <= res_full;
      end
      if (cmd.emit) begin
         rsp_data_ff <= {(RSP_DATA_W - COUNT_W - 3)'(0), count_ext[COUNT_W-1:0],
                         res_full_ff, res_pkt_ff, res_changed_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule : dvrt_dp

`default_nettype wire

// File: rtl/distance_vector_route_table_core.sv
// Top level of the distance-vector route table core.
// Depends on dvrt_pkg, dvrt_ctrl and dvrt_dp.
`default_nettype none

// Distance-vector route table. Each request carries one operation in
// req_tuser: clear the table, append a neighbour route, append the self route,
// or apply one advertised route of a neighbour's update packet (saturating cost
// add, first-match search, split-horizon improvement, forced follow of routes
// through the sender, append when unknown). Each request yields exactly one
// response. Clear and the two append operations step through an execute state
// and an emit state. Applying an advertised route scans the table from entry 0
// until the match or the fill count: the route memory has one read port and is
// scanned one entry per cycle. The output register holds a response while the
// next request is already being worked on; a response still held off by the
// receiver stalls the next one in its final step, and with it the request side.
// The table memory needs no clearing pass; entries above the fill count are
// never read. The router id register is written through the csr_ port; the
// user must write it only while the core is idle; the core does not enforce it.
module distance_vector_route_table_core
   import dvrt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [7:0] dest_id, [15:8] adv_next_hop, [31:16] adv_cost,
   // [39:32] sender, [55:40] link_cost
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] func
   input  wire logic [FUNC_W-1:0]     req_tuser,
   // last_of_packet
   input  wire logic                  req_tlast,
   // Response channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] entry_changed, [1] packet_changed, [2] table_full,
   // [8:3] route_count, [15:9] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // Router id register write.
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [ID_W-1:0]       csr_data
);

   dvrt_cmd_type    cmd;
   dvrt_status_type status;

   // Always take register writes; each is registered into the router id register.
   assign csr_ready = 1'b1;

   // Sequence each request through the datapath.
   dvrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   // Hold the table, search it and build the response.
   dvrt_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule : distance_vector_route_table_core

`default_nettype wire

// File: rtl/dvrt_checker.sv
// Port-level checks of the route table core, bound to the top level.
// Depends on dvrt_pkg for the field widths.
`default_nettype none

module dvrt_checker
   import dvrt_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // A dropped insert never reports a change.
   a_full_no_change: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[0])
      else $error("table_full with entry_changed");

   // One request at a time: busy right after an acceptance.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // No response straight out of reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule : dvrt_checker

bind distance_vector_route_table_core dvrt_checker u_dvrt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
